>>> hw/rtl/assert_macros.svh
// assertion macros used by caesar_vigenere_decryptor
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, disabled while reset is asserted
`define CVD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cvd assertion failed");

// checked property, also evaluated during reset
`define CVD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("cvd assertion failed");

`endif

>>> hw/rtl/cvd_pkg.sv
// shared types, constants and helper functions of the alphanumeric decryptor
// no dependencies
`default_nettype none

package cvd_pkg;

  localparam int unsigned MaxKeyLen = 8;
  localparam int unsigned CharW     = 8;
  localparam int unsigned KeyPosW   = $clog2(MaxKeyLen);
  localparam int unsigned KeyLenW   = 4;
  localparam int unsigned ShiftsW   = MaxKeyLen * CharW;
  localparam int unsigned SpanW     = 5;

  // configuration register indexes
  typedef enum logic {
    RegKeyLength = 1'b0,
    RegKeyShifts = 1'b1
  } cfg_reg_e;

  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;
  localparam logic [CharW-1:0] CharUpA  = 8'h41;
  localparam logic [CharW-1:0] CharUpZ  = 8'h5A;
  localparam logic [CharW-1:0] CharLoA  = 8'h61;
  localparam logic [CharW-1:0] CharLoZ  = 8'h7A;

  localparam logic [SpanW-1:0] DigitSpan = 5'd10;
  localparam logic [SpanW-1:0] AlphaSpan = 5'd26;

  // shift modulo 10 by a chain of conditional subtractions
  function automatic logic [SpanW-1:0] mod_ten(logic [CharW-1:0] v);
    logic [CharW-1:0] r;
    r = v;
    if (r >= 8'd160) r = r - 8'd160;
    if (r >= 8'd80)  r = r - 8'd80;
    if (r >= 8'd40)  r = r - 8'd40;
    if (r >= 8'd20)  r = r - 8'd20;
    if (r >= 8'd10)  r = r - 8'd10;
    return r[SpanW-1:0];
  endfunction

  // shift modulo 26 by a chain of conditional subtractions
  function automatic logic [SpanW-1:0] mod_twentysix(logic [CharW-1:0] v);
    logic [CharW-1:0] r;
    r = v;
    if (r >= 8'd208) r = r - 8'd208;
    if (r >= 8'd104) r = r - 8'd104;
    if (r >= 8'd52)  r = r - 8'd52;
    if (r >= 8'd26)  r = r - 8'd26;
    return r[SpanW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/caesar_vigenere_decryptor.sv
// Streaming Vigenere / Caesar decryptor for alphanumeric ASCII bytes.
// Requests arrive on the in channel (cipher_char_i, last_char_i) with a
// valid/ready handshake; one decrypted byte per request leaves on the out
// channel (plain_char_o, last_out_o), also valid/ready.
// Each request picks the key shift at the current key position when it is
// accepted; the position steps by one, wraps at the key length and returns
// to zero after a byte marked last.
// A request that is accepted passes the input register, then the result
// register, before it is valid at the output. Throughput is one request per
// cycle while the receiver does not stall; the decode is a single pass of
// compare and subtract logic between the two registers.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready_o drops once both are full.
// Reset empties both registers, sets key length to one, all shifts to
// zero and the key position to zero.
// Configuration: cfg_we_i writes register cfg_index_i (0 key length,
// 1 packed key shifts) from cfg_data_i; write only while idle.
// depends on cvd_pkg, cvd_char_decode and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module caesar_vigenere_decryptor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_index_i,
  input  wire logic [cvd_pkg::ShiftsW-1:0]    cfg_data_i,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [cvd_pkg::CharW-1:0]      cipher_char_i,
  input  wire logic                           last_char_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [cvd_pkg::CharW-1:0]      plain_char_o,
  output logic                                last_out_o
);
  import cvd_pkg::*;

  logic [KeyLenW-1:0] key_len_q;
  logic [ShiftsW-1:0] key_shifts_q;
  logic [KeyPosW-1:0] key_pos_q;
  logic [KeyPosW-1:0] key_pos_d;
  logic [KeyLenW-1:0] eff_len;
  logic [KeyLenW-1:0] pos_inc;

  logic               in_accept;
  logic               s1_valid_q;
  logic               s1_valid_d;
  logic [CharW-1:0]   s1_char_q;
  logic               s1_last_q;
  logic [CharW-1:0]   s1_shift_q;
  logic [CharW-1:0]   cur_shift;

  logic               out_load;
  logic               out_free;
  logic               out_valid_q;
  logic               out_valid_d;
  logic [CharW-1:0]   plain_q;
  logic               last_q;
  logic [CharW-1:0]   plain_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q    <= KeyLenW'(1);
      key_shifts_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegKeyLength: key_len_q    <= cfg_data_i[KeyLenW-1:0];
        RegKeyShifts: key_shifts_q <= cfg_data_i;
        default:      key_len_q    <= key_len_q;
      endcase
    end
  end

  // handshake of the two stages
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  // effective key length, zero read as one, saturated at the maximum
  always_comb begin
    eff_len = key_len_q;
    if (key_len_q == '0) begin
      eff_len = KeyLenW'(1);
    end else if (key_len_q > KeyLenW'(MaxKeyLen)) begin
      eff_len = KeyLenW'(MaxKeyLen);
    end
  end

  // key position advance
  assign pos_inc = {{(KeyLenW-KeyPosW){1'b0}}, key_pos_q} + KeyLenW'(1);

  always_comb begin
    key_pos_d = key_pos_q;
    if (in_accept) begin
      if (last_char_i || (pos_inc >= eff_len)) begin
        key_pos_d = '0;
      end else begin
        key_pos_d = pos_inc[KeyPosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q <= '0;
    end else begin
      key_pos_q <= key_pos_d;
    end
  end

  // shift entry at the current position
  assign cur_shift = key_shifts_q[{key_pos_q, 3'b000} +: CharW];

  // input register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_char_q  <= cipher_char_i;
      s1_last_q  <= last_char_i;
      s1_shift_q <= cur_shift;
    end
  end

  // byte decode between the registers
  cvd_char_decode u_decode (
    .cipher_i (s1_char_q),
    .shift_i  (s1_shift_q),
    .plain_o  (plain_d)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      plain_q <= plain_d;
      last_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign plain_char_o = plain_q;
  assign last_out_o   = last_q;

  // checks
  `CVD_ASSERT(a_last_resets_pos, in_accept && last_char_i |=> key_pos_q == '0)
  `CVD_ASSERT(a_full_blocks_input, s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
  `CVD_ASSERT(a_space_passes, out_load && (s1_char_q == 8'h20) |=> plain_char_o == 8'h20)
  `CVD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o && in_ready_o)

endmodule

`default_nettype wire

>>> hw/rtl/cvd_char_decode.sv
// combinational back shift of one byte within 0-9, A-Z or a-z
// depends on cvd_pkg
`default_nettype none

module cvd_char_decode (
  input  wire logic [cvd_pkg::CharW-1:0] cipher_i,
  input  wire logic [cvd_pkg::CharW-1:0] shift_i,
  output logic      [cvd_pkg::CharW-1:0] plain_o
);
  import cvd_pkg::*;

  logic             is_digit;
  logic             is_upper;
  logic             is_lower;
  logic [CharW-1:0] base;
  logic [SpanW-1:0] span;
  logic [SpanW-1:0] shift_red;
  logic [SpanW-1:0] offset;
  logic [SpanW:0]   wrap_sum;
  logic [SpanW:0]   wrap_red;
  logic [CharW-1:0] offset_diff;

  // character class
  assign is_digit = (cipher_i >= CharZero) && (cipher_i <= CharNine);
  assign is_upper = (cipher_i >= CharUpA) && (cipher_i <= CharUpZ);
  assign is_lower = (cipher_i >= CharLoA) && (cipher_i <= CharLoZ);

  // base and span of the class, shift reduced into the span
  always_comb begin
    base      = CharZero;
    span      = DigitSpan;
    shift_red = mod_ten(shift_i);
    if (is_upper) begin
      base      = CharUpA;
      span      = AlphaSpan;
      shift_red = mod_twentysix(shift_i);
    end else if (is_lower) begin
      base      = CharLoA;
      span      = AlphaSpan;
      shift_red = mod_twentysix(shift_i);
    end
  end

  assign offset_diff = cipher_i - base;
  assign offset      = offset_diff[SpanW-1:0];

  // move back by the shift and wrap once within the span
  assign wrap_sum = {1'b0, offset} + {1'b0, span} - {1'b0, shift_red};
  assign wrap_red = (wrap_sum >= {1'b0, span}) ? (wrap_sum - {1'b0, span}) : wrap_sum;

  // other bytes pass unchanged
  assign plain_o = (is_digit || is_upper || is_lower)
                 ? (base + {{(CharW-SpanW-1){1'b0}}, wrap_red})
                 : cipher_i;

endmodule

`default_nettype wire
